// File: design/tbrm_pkg.sv
// Shared types, constants and constant functions for the rotation matrix unit.
// Holds the CORDIC lane type, the arctangent table and the gain computation.
// No dependencies.
package tbrm_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int STAGES_DEF     = 16;
    localparam int MAX_STAGES     = 32;
    localparam int W_IO           = 16;
    localparam int W_XY           = 34;
    localparam int W_ACC          = 36;
    localparam int WORK_FRAC      = 30;

    typedef struct packed {
        logic signed [W_XY-1:0] x;
        logic signed [W_XY-1:0] y;
        logic signed [W_XY-1:0] z;
        logic                   flip;
    } t_lane;

    typedef logic signed [W_XY-1:0] t_q30;

    // atan(2^-i) in 32-bit turn units
    function automatic logic [31:0] f_atan(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'h20000000;  1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;  3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;  5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;  7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;  9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;  11: a = 32'h000517CC;
            12: a = 32'h00028BE6;  13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;  15: a = 32'h0000517D;
            16: a = 32'h000028BE;  17: a = 32'h0000145F;
            18: a = 32'h00000A30;  19: a = 32'h00000518;
            20: a = 32'h0000028C;  21: a = 32'h00000146;
            22: a = 32'h000000A3;  23: a = 32'h00000051;
            24: a = 32'h00000029;  25: a = 32'h00000014;
            26: a = 32'h0000000A;  27: a = 32'h00000005;
            28: a = 32'h00000003;  29: a = 32'h00000001;
            30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // Gain compensation K in Q30 for n stages, evaluated at elaboration
    function automatic longint unsigned f_gain(input int n);
        longint unsigned p;
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        longint unsigned num;
        longint unsigned rem;
        longint unsigned q;
        p = 64'd1 << WORK_FRAC;
        for (int i = 0; i < MAX_STAGES; i++) begin
            if (i < n) p = p + (p >> (2 * i));
        end
        v   = p << WORK_FRAC;
        res = 0;
        bt  = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bt > v) bt = bt >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (bt != 0) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        if (res == 0) res = 1;
        num = (64'd1 << 60) + (res >> 1);
        rem = 0;
        q   = 0;
        for (int k = 63; k >= 0; k--) begin
            rem = (rem << 1) | longint'(num[k]);
            if (rem >= res) begin
                rem  = rem - res;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q30 product, rounded half up
    function automatic t_q30 f_mul(input t_q30 a, input t_q30 b);
        logic signed [2*W_XY-1:0] p;
        p = ((2*W_XY)'(a) * (2*W_XY)'(b) + ((2*W_XY)'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
        return p[W_XY-1:0];
    endfunction

endpackage

// File: design/tait_bryan_rotation_matrix_unit.sv
// Tait-Bryan rotation matrix from three binary angles, via a chain of CORDIC cells.
// Pipeline: the chain of CORDIC cells, then the product pipeline of tbrm_matrix, from input beat to output beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output beat is stalled.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// Depends on tbrm_pkg, tbrm_cell and tbrm_matrix.
module tait_bryan_rotation_matrix_unit #(
    parameter int ANGLE_BITS    = tbrm_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS     = tbrm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = tbrm_pkg::STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [tbrm_pkg::W_IO-1:0] i_angle_x,
    input  logic signed [tbrm_pkg::W_IO-1:0] i_angle_y,
    input  logic signed [tbrm_pkg::W_IO-1:0] i_angle_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row0_col0,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row0_col1,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row0_col2,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row1_col0,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row1_col1,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row1_col2,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row2_col0,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row2_col1,
    output logic signed [tbrm_pkg::W_IO-1:0] o_row2_col2
);
    import tbrm_pkg::*;

    localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam t_q30 GAIN = t_q30'(f_gain(NS));

    logic en;
    logic [W_IO-1:0] angles [3];
    t_lane [2:0] lane [NS+1];
    logic        vld  [NS+1];
    logic [8:0][W_IO-1:0] ent;

    // advance everything unless the output beat is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign angles[0] = i_angle_x;
    assign angles[1] = i_angle_y;
    assign angles[2] = i_angle_z;

    // move to 32-bit turn units; fold the left half-plane by pi
    always_comb begin
        logic [31:0] u;
        for (int l = 0; l < 3; l++) begin
            u = 32'(angles[l]) << (32 - ANGLE_BITS);
            lane[0][l].flip = u[31] ^ u[30];
            u[31]           = u[31] ^ (u[31] ^ u[30]);
            lane[0][l].x    = GAIN;
            lane[0][l].y    = '0;
            lane[0][l].z    = W_XY'(signed'(u));
        end
    end
    assign vld[0] = i_valid;

    for (genvar s = 0; s < NS; s++) begin : g_cell
        tbrm_cell #(.STAGE(s)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (vld[s]),
            .i_lane  (lane[s]),
            .o_valid (vld[s+1]),
            .o_lane  (lane[s+1])
        );
    end

    tbrm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vld[NS]),
        .i_lane  (lane[NS]),
        .o_valid (o_valid),
        .o_ent   (ent)
    );

    assign o_row0_col0 = ent[0];
    assign o_row0_col1 = ent[1];
    assign o_row0_col2 = ent[2];
    assign o_row1_col0 = ent[3];
    assign o_row1_col1 = ent[4];
    assign o_row1_col2 = ent[5];
    assign o_row2_col0 = ent[6];
    assign o_row2_col1 = ent[7];
    assign o_row2_col2 = ent[8];

endmodule

// File: design/tbrm_cell.sv
// One CORDIC rotation cell: a single micro-rotation for the x, y and z angle lanes.
// Depends on tbrm_pkg.
module tbrm_cell #(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  tbrm_pkg::t_lane [2:0] i_lane,
    output logic                  o_valid,
    output tbrm_pkg::t_lane [2:0] o_lane
);
    import tbrm_pkg::*;

    localparam t_q30 ATAN = t_q30'(f_atan(STAGE));

    logic  r_valid;
    t_lane [2:0] r_lane;
    t_lane [2:0] n_lane;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_lane[l].flip = i_lane[l].flip;
            if (!i_lane[l].z[W_XY-1]) begin
                n_lane[l].x = i_lane[l].x - (i_lane[l].y >>> STAGE);
                n_lane[l].y = i_lane[l].y + (i_lane[l].x >>> STAGE);
                n_lane[l].z = i_lane[l].z - ATAN;
            end else begin
                n_lane[l].x = i_lane[l].x + (i_lane[l].y >>> STAGE);
                n_lane[l].y = i_lane[l].y - (i_lane[l].x >>> STAGE);
                n_lane[l].z = i_lane[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: design/tbrm_matrix.sv
// Product pipeline: sine/cosine fixup, two product levels, sums, rounding, saturation.
// Depends on tbrm_pkg.
module tbrm_matrix #(
    parameter int FRAC_BITS = tbrm_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tbrm_pkg::t_lane [2:0]               i_lane,
    output logic                                o_valid,
    output logic [8:0][tbrm_pkg::W_IO-1:0]      o_ent
);
    import tbrm_pkg::*;

    localparam int SH = WORK_FRAC - FRAC_BITS;
    localparam logic signed [W_ACC:0] RND = ((W_ACC+1)'(1) <<< SH) >>> 1;
    localparam logic signed [W_ACC:0] ONE = (W_ACC+1)'(1) <<< FRAC_BITS;

    function automatic logic [W_IO-1:0] f_fin(input logic signed [W_ACC-1:0] v);
        logic signed [W_ACC:0] t;
        t = ((W_ACC+1)'(v) + RND) >>> SH;
        if (t > ONE)  t = ONE;
        if (t < -ONE) t = -ONE;
        return t[W_IO-1:0];
    endfunction

    t_q30 sx, cx, sy, cy, sz, cz;

    // undo the half-turn shift
    always_comb begin
        cx = i_lane[0].flip ? -i_lane[0].x : i_lane[0].x;
        sx = i_lane[0].flip ? -i_lane[0].y : i_lane[0].y;
        cy = i_lane[1].flip ? -i_lane[1].x : i_lane[1].x;
        sy = i_lane[1].flip ? -i_lane[1].y : i_lane[1].y;
        cz = i_lane[2].flip ? -i_lane[2].x : i_lane[2].x;
        sz = i_lane[2].flip ? -i_lane[2].y : i_lane[2].y;
    end

    logic r_va, r_vb, r_vc;
    t_q30 r_cycz, r_cxsz, r_sxsz, r_cysz, r_cxcz, r_sxcz, r_sxcy, r_cxcy;
    t_q30 r_sxsy, r_cxsy, r_cz, r_sz, r_sy;
    t_q30 r_b_cycz, r_b_cxsz, r_b_sxsz, r_b_cysz, r_b_cxcz, r_b_sxcz, r_b_sxcy, r_b_cxcy;
    t_q30 r_b_sy, r_sxsycz, r_cxsycz, r_sxsysz, r_cxsysz;
    logic [8:0][W_IO-1:0] r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cycz <= f_mul(cy, cz);
            r_cxsz <= f_mul(cx, sz);
            r_sxsz <= f_mul(sx, sz);
            r_cysz <= f_mul(cy, sz);
            r_cxcz <= f_mul(cx, cz);
            r_sxcz <= f_mul(sx, cz);
            r_sxcy <= f_mul(sx, cy);
            r_cxcy <= f_mul(cx, cy);
            r_sxsy <= f_mul(sx, sy);
            r_cxsy <= f_mul(cx, sy);
            r_cz   <= cz;
            r_sz   <= sz;
            r_sy   <= sy;

            r_b_cycz <= r_cycz;
            r_b_cxsz <= r_cxsz;
            r_b_sxsz <= r_sxsz;
            r_b_cysz <= r_cysz;
            r_b_cxcz <= r_cxcz;
            r_b_sxcz <= r_sxcz;
            r_b_sxcy <= r_sxcy;
            r_b_cxcy <= r_cxcy;
            r_b_sy   <= r_sy;
            r_sxsycz <= f_mul(r_sxsy, r_cz);
            r_cxsycz <= f_mul(r_cxsy, r_cz);
            r_sxsysz <= f_mul(r_sxsy, r_sz);
            r_cxsysz <= f_mul(r_cxsy, r_sz);

            r_ent[0] <= f_fin(W_ACC'(r_b_cycz));
            r_ent[1] <= f_fin(W_ACC'(r_b_cxsz) + W_ACC'(r_sxsycz));
            r_ent[2] <= f_fin(W_ACC'(r_b_sxsz) - W_ACC'(r_cxsycz));
            r_ent[3] <= f_fin(-W_ACC'(r_b_cysz));
            r_ent[4] <= f_fin(W_ACC'(r_b_cxcz) - W_ACC'(r_sxsysz));
            r_ent[5] <= f_fin(W_ACC'(r_b_sxcz) + W_ACC'(r_cxsysz));
            r_ent[6] <= f_fin(W_ACC'(r_b_sy));
            r_ent[7] <= f_fin(-W_ACC'(r_b_sxcy));
            r_ent[8] <= f_fin(W_ACC'(r_b_cxcy));
        end
    end

    assign o_valid = r_vc;
    assign o_ent   = r_ent;

endmodule
